// File: sv/cfla_pkg.sv
package cfla_pkg;

  localparam int unsigned ADDR_W   = 21;
  localparam int unsigned LOG2_W   = 4;
  localparam int unsigned CNT_W    = 8;
  localparam logic [LOG2_W-1:0] MAX_LOG2   = 4'd12;
  localparam logic [LOG2_W-1:0] RESET_LOG2 = 4'd3;
  localparam logic [CNT_W-1:0]  CNT_MAX    = 8'd255;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_OOM     = 2'd1,
    STAT_BADADDR = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_SCAN,
    S_ALLOC_READ,
    S_ALLOC_POP,
    S_FREE_SCAN,
    S_FREE_WRITE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic                func;
    logic [ADDR_W-1:0]   free_addr;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   alloc_addr;
    status_e             status;
  } out_word_t;

  typedef struct packed {
    logic at_end;
    logic rem_lt;
  } scan_flags_t;

endpackage

// File: sv/cfla_link_mem.sv
module cfla_link_mem
  import cfla_pkg::*;
#(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9,
  parameter int unsigned DW    = 7
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/cfla_step_unit.sv
module cfla_step_unit
  import cfla_pkg::*;
#(
  parameter int unsigned BPC = 64,
  parameter int unsigned CW  = 4,
  parameter int unsigned BSW = 10
) (
  input  logic [CW-1:0]     cidx_i,
  input  logic [CW-1:0]     open_i,
  input  logic [BSW-1:0]    base_i,
  input  logic [ADDR_W-1:0] rem_i,
  output scan_flags_t       flags_o,
  output logic [CW-1:0]     cidx_o,
  output logic [BSW-1:0]    base_o,
  output logic [ADDR_W-1:0] rem_o
);

  localparam logic [ADDR_W-1:0] BPC_R = ADDR_W'(BPC);
  localparam logic [BSW-1:0]    BPC_S = BSW'(BPC);

  // One chunk step: compare against the open count and the chunk size, then advance.
  assign flags_o.at_end = (cidx_i >= open_i);
  assign flags_o.rem_lt = (rem_i < BPC_R);
  assign cidx_o         = cidx_i + CW'(1);
  assign base_o         = base_i + BPC_S;
  assign rem_o          = rem_i - BPC_R;

endmodule

// File: sv/chunked_free_list_allocator.sv
// Channel  Direction  Handshake               Word
// in       input      in_valid_i / in_stall_o   in_word_t (func, free_addr)
// out      output     out_valid_o / out_stall_i out_word_t (alloc_addr, status)
// cfg      input      cfg_we_i                  cfg_wdata_i (block_size_log2)
//
// An allocate passes S_ALLOC_SCAN, stepping over opened chunks at one chunk per cycle,
// S_ALLOC_READ, S_ALLOC_POP and S_RESP; a free passes S_FREE_SCAN up to its chunk,
// S_FREE_WRITE and S_RESP. A refusal for lack of memory or an unopened chunk goes from
// the scan to S_RESP, a damaged list from S_ALLOC_READ. After reset the link memory is
// swept once, MAX_CHUNKS * BLOCKS_PER_CHUNK entries (512 by default), while the input
// is stalled. A stalled result holds in the output register; the next word is taken after it.
module chunked_free_list_allocator
  import cfla_pkg::*;
#(
  parameter int unsigned BLOCKS_PER_CHUNK = 64,
  parameter int unsigned MAX_CHUNKS       = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o,
  input  logic              cfg_we_i,
  input  logic [LOG2_W-1:0] cfg_wdata_i
);

  localparam int unsigned DEPTH = MAX_CHUNKS * BLOCKS_PER_CHUNK;
  localparam int unsigned MW    = $clog2(DEPTH);
  localparam int unsigned BW    = $clog2(BLOCKS_PER_CHUNK + 1);
  localparam int unsigned CW    = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned CIW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int unsigned BSW   = $clog2(DEPTH + 1);
  localparam logic [BW-1:0]    BPC_B   = BW'(BLOCKS_PER_CHUNK);
  localparam logic [BW-1:0]    LAST_B  = BW'(BLOCKS_PER_CHUNK - 1);
  localparam logic [CNT_W-1:0] BPC_C   = CNT_W'(BLOCKS_PER_CHUNK);
  localparam logic [CW-1:0]    MAXC    = CW'(MAX_CHUNKS);
  localparam logic [MW-1:0]    LAST_M  = MW'(DEPTH - 1);

  state_e            state_q, state_d;
  logic [LOG2_W-1:0] log2_q;
  logic [LOG2_W-1:0] eff_log2;
  logic [CW-1:0]     open_q, open_d;
  logic [CW-1:0]     cidx_q, cidx_d;
  logic [BSW-1:0]    base_q, base_d;
  logic [ADDR_W-1:0] rem_q, rem_d;
  logic [MW-1:0]     clr_q;
  logic [BW-1:0]     clr_blk_q;
  out_word_t         res_q, res_d;
  out_word_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [BW-1:0]     head_q  [MAX_CHUNKS];
  logic [CNT_W-1:0]  count_q [MAX_CHUNKS];
  logic              tbl_we;
  logic [BW-1:0]     tbl_head_wd;
  logic [CNT_W-1:0]  tbl_cnt_wd;
  logic [CIW-1:0]    ci;
  logic [BW-1:0]     cur_head;
  logic [CNT_W-1:0]  cur_count;

  scan_flags_t       flags;
  logic [CW-1:0]     cidx_nxt;
  logic [BSW-1:0]    base_nxt;
  logic [ADDR_W-1:0] rem_nxt;

  logic              mem_we, mem_re;
  logic [MW-1:0]     mem_waddr, mem_raddr;
  logic [BW-1:0]     mem_wdata, mem_rdata;
  logic [BW-1:0]     blk;
  logic [BSW-1:0]    alloc_idx;
  logic [ADDR_W-1:0] alloc_addr;

  assign eff_log2   = (log2_q > MAX_LOG2) ? MAX_LOG2 : log2_q;
  assign ci         = cidx_q[CIW-1:0];
  assign cur_head   = head_q[ci];
  assign cur_count  = count_q[ci];
  assign blk        = rem_q[BW-1:0];
  assign alloc_idx  = base_q + BSW'(cur_head);
  assign alloc_addr = ADDR_W'(alloc_idx) << eff_log2;

  cfla_step_unit #(
    .BPC (BLOCKS_PER_CHUNK),
    .CW  (CW),
    .BSW (BSW)
  ) u_step (
    .cidx_i  (cidx_q),
    .open_i  (open_q),
    .base_i  (base_q),
    .rem_i   (rem_q),
    .flags_o (flags),
    .cidx_o  (cidx_nxt),
    .base_o  (base_nxt),
    .rem_o   (rem_nxt)
  );

  cfla_link_mem #(
    .DEPTH (DEPTH),
    .AW    (MW),
    .DW    (BW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      log2_q      <= RESET_LOG2;
      open_q      <= CW'(1);
      cidx_q      <= '0;
      base_q      <= '0;
      clr_q       <= '0;
      clr_blk_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      open_q      <= open_d;
      cidx_q      <= cidx_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        log2_q <= cfg_wdata_i;
      end
      if (state_q == S_CLEAR) begin
        clr_q     <= clr_q + MW'(1);
        clr_blk_q <= (clr_blk_q == LAST_B) ? '0 : clr_blk_q + BW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_CHUNKS); i++) begin
        head_q[i]  <= '0;
        count_q[i] <= BPC_C;
      end
    end else if (tbl_we) begin
      head_q[ci]  <= tbl_head_wd;
      count_q[ci] <= tbl_cnt_wd;
    end
  end

  always_comb begin
    state_d     = state_q;
    open_d      = open_q;
    cidx_d      = cidx_q;
    base_d      = base_q;
    rem_d       = rem_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    tbl_we      = 1'b0;
    tbl_head_wd = cur_head;
    tbl_cnt_wd  = cur_count;
    mem_we      = 1'b0;
    mem_waddr   = clr_q;
    mem_wdata   = clr_blk_q + BW'(1);
    mem_re      = 1'b0;
    mem_raddr   = MW'(alloc_idx);
    in_stall_o  = 1'b1;

    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_q == LAST_M) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        cidx_d     = '0;
        base_d     = '0;
        rem_d      = in_word_i.free_addr >> eff_log2;
        if (in_valid_i) begin
          state_d = (in_word_i.func == FUNC_FREE) ? S_FREE_SCAN : S_ALLOC_SCAN;
        end
      end
      S_ALLOC_SCAN: begin
        if (flags.at_end) begin
          if (open_q == MAXC) begin
            res_d   = '{alloc_addr: '0, status: STAT_OOM};
            state_d = S_RESP;
          end else begin
            open_d  = open_q + CW'(1);
            state_d = S_ALLOC_READ;
          end
        end else if (cur_count != '0) begin
          state_d = S_ALLOC_READ;
        end else begin
          cidx_d = cidx_nxt;
          base_d = base_nxt;
        end
      end
      S_ALLOC_READ: begin
        if (cur_head >= BPC_B) begin
          res_d   = '{alloc_addr: '0, status: STAT_OOM};
          state_d = S_RESP;
        end else begin
          mem_re  = 1'b1;
          res_d   = '{alloc_addr: alloc_addr, status: STAT_OK};
          state_d = S_ALLOC_POP;
        end
      end
      S_ALLOC_POP: begin
        tbl_we      = 1'b1;
        tbl_head_wd = mem_rdata;
        tbl_cnt_wd  = cur_count - CNT_W'(1);
        state_d     = S_RESP;
      end
      S_FREE_SCAN: begin
        if (flags.at_end) begin
          res_d   = '{alloc_addr: '0, status: STAT_BADADDR};
          state_d = S_RESP;
        end else if (flags.rem_lt) begin
          state_d = S_FREE_WRITE;
        end else begin
          cidx_d = cidx_nxt;
          base_d = base_nxt;
          rem_d  = rem_nxt;
        end
      end
      S_FREE_WRITE: begin
        mem_we      = 1'b1;
        mem_waddr   = MW'(base_q + BSW'(blk));
        mem_wdata   = cur_head;
        tbl_we      = 1'b1;
        tbl_head_wd = blk;
        tbl_cnt_wd  = (cur_count == CNT_MAX) ? cur_count : cur_count + CNT_W'(1);
        res_d       = '{alloc_addr: '0, status: STAT_OK};
        state_d     = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_open_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_q >= CW'(1)) && (open_q <= MAXC))
    else $error("open chunk count out of range");

  a_open_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_q != $past(open_q)) |->
      ((open_q == $past(open_q) + CW'(1)) && ($past(state_q) == S_ALLOC_SCAN)))
    else $error("open chunk count changed outside the allocate scan");

  a_chunk_opened: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_ALLOC_READ) || (state_q == S_ALLOC_POP) || (state_q == S_FREE_WRITE))
      |-> (cidx_q < open_q))
    else $error("table access to a chunk that is not open");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC_POP) |-> (cur_count != '0))
    else $error("pop from a chunk with no free block");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_RESP))
    else $error("result presented without a response step");

endmodule
